// ===== sv/pafk_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pafk_pkg
// Shared constants, types and arithmetic helpers of the planar arm forward
// kinematics core.
// ----------------------------------------------------------------------------
package pafk_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ATAN_ENTRIES     = 30;

  localparam int ANG_W    = 16;
  localparam int SUM_A_W  = ANG_W + 1;
  localparam int SUM_B_W  = ANG_W + 2;
  localparam int STROKE_W = 18;
  localparam int OUT_W    = 18;
  localparam int LEN_W    = 16;
  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 72;
  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;

  localparam int ANG_SHIFT   = 17;
  localparam int WRAP_W      = 36;
  localparam int WRAP_STEPS  = 3;
  localparam int Z_W         = 33;
  localparam int XY_W        = 32;
  localparam int PROD_W      = LEN_W + 1 + XY_W;
  localparam int SUM_W       = PROD_W + 1;
  localparam int ROUND_SHIFT = 31;

  localparam logic [LEN_W-1:0] LINK_RESET = 16'd9830;

  localparam logic REG_FIRST_LINK  = 1'b0;
  localparam logic REG_SECOND_LINK = 1'b1;

  localparam logic signed [WRAP_W-1:0] PI_Q30      = 36'sd3373259426;
  localparam logic signed [WRAP_W-1:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [WRAP_W-1:0] TWO_PI_Q30  = 36'sd6746518852;
  localparam logic signed [XY_W-1:0]   GAIN_Q30    = 32'sd652032874;
  localparam logic signed [SUM_W-1:0]  ROUND_Q45   = SUM_W'(1) << (ROUND_SHIFT - 1);
  localparam logic signed [SUM_W-1:0]  OUT_MAX     = SUM_W'(131071);
  localparam logic signed [SUM_W-1:0]  OUT_MIN     = -SUM_W'(131072);

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
  } cordic_t;

  typedef struct packed {
    logic signed [STROKE_W-1:0] stroke;
    logic signed [SUM_B_W-1:0]  tool;
  } meta_t;

  typedef struct packed {
    logic                  flip;
    logic signed [Z_W-1:0] z;
  } fold_t;

  function automatic logic [31:0] atan_q30(input int idx);
    logic [31:0] r;
    unique case (idx)
      0:  r = 32'h3243F6A8;
      1:  r = 32'h1DAC6705;
      2:  r = 32'h0FADBAFC;
      3:  r = 32'h07F56EA6;
      4:  r = 32'h03FEAB76;
      5:  r = 32'h01FFD55B;
      6:  r = 32'h00FFFAAA;
      7:  r = 32'h007FFF55;
      8:  r = 32'h003FFFEA;
      9:  r = 32'h001FFFFD;
      10: r = 32'h000FFFFF;
      11: r = 32'h0007FFFF;
      12: r = 32'h0003FFFF;
      13: r = 32'h0001FFFF;
      14: r = 32'h0000FFFF;
      15: r = 32'h00007FFF;
      16: r = 32'h00003FFF;
      17: r = 32'h00001FFF;
      18: r = 32'h00000FFF;
      19: r = 32'h000007FF;
      20: r = 32'h000003FF;
      21: r = 32'h000001FF;
      22: r = 32'h000000FF;
      23: r = 32'h0000007F;
      24: r = 32'h0000003F;
      25: r = 32'h0000001F;
      26: r = 32'h0000000F;
      27: r = 32'h00000008;
      28: r = 32'h00000004;
      29: r = 32'h00000002;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

  // one step of 2*pi toward [-pi, pi)
  function automatic logic signed [WRAP_W-1:0] wrap_step(input logic signed [WRAP_W-1:0] z);
    logic signed [WRAP_W-1:0] r;
    if (z >= PI_Q30) begin
      r = z - TWO_PI_Q30;
    end else if (z < -PI_Q30) begin
      r = z + TWO_PI_Q30;
    end else begin
      r = z;
    end
    return r;
  endfunction

  // fold into [-pi/2, pi/2], result negated later
  function automatic fold_t fold_half(input logic signed [WRAP_W-1:0] z);
    fold_t                    f;
    logic signed [WRAP_W-1:0] t;
    if (z > HALF_PI_Q30) begin
      t      = z - PI_Q30;
      f.flip = 1'b1;
    end else if (z < -HALF_PI_Q30) begin
      t      = z + PI_Q30;
      f.flip = 1'b1;
    end else begin
      t      = z;
      f.flip = 1'b0;
    end
    f.z = t[Z_W-1:0];
    return f;
  endfunction

  function automatic cordic_t cordic_step(input cordic_t c, input int i);
    cordic_t                r;
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [XY_W-1:0] xs;
    logic signed [XY_W-1:0] ys;
    logic signed [Z_W-1:0]  z;
    logic signed [Z_W-1:0]  at;
    x  = c.x;
    y  = c.y;
    z  = c.z;
    xs = x >>> i;
    ys = y >>> i;
    at = Z_W'(atan_q30(i));
    if (!z[Z_W-1]) begin
      r.x = x - ys;
      r.y = y + xs;
      r.z = z - at;
    end else begin
      r.x = x + ys;
      r.y = y - xs;
      r.z = z + at;
    end
    return r;
  endfunction

  function automatic logic [OUT_W-1:0] sat_q14(input logic signed [SUM_W-1:0] s);
    logic signed [SUM_W-1:0] v;
    logic [OUT_W-1:0]        r;
    v = (s + ROUND_Q45) >>> ROUND_SHIFT;
    if (v > OUT_MAX) begin
      r = OUT_MAX[OUT_W-1:0];
    end else if (v < OUT_MIN) begin
      r = OUT_MIN[OUT_W-1:0];
    end else begin
      r = v[OUT_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== sv/planar_arm_forward_kinematics_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// planar_arm_forward_kinematics_core
// Tool pose of a two-link planar arm with a vertical prismatic axis.
// ----------------------------------------------------------------------------
// Takes one word per clock and returns one word per clock unless the pipeline
// holds. Each accepted word passes, in order: input sums, three angle wrap
// steps, a half-plane fold, one CORDIC rotation per stage for both angle sums
// in parallel, sign restore, link length products, and a round and saturate
// stage, and then m_tvalid rises. A two-entry output buffer keeps the input
// open while a result waits; the pipeline holds only when both entries are
// full. Link lengths are read live, so write them only while the core is
// empty.
module planar_arm_forward_kinematics_core #(
  parameter int CORDIC_STEPS = pafk_pkg::CORDIC_STEPS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // base_angle[15:0], shoulder_angle[31:16], elbow_angle[47:32], stroke[65:48]
  input  logic [pafk_pkg::IN_TDATA_W-1:0]     s_tdata,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // pos_x[17:0], pos_y[35:18], pos_z[53:36], tool_angle[71:54]
  output logic [pafk_pkg::OUT_TDATA_W-1:0]    m_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [pafk_pkg::APB_AW-1:0]         paddr,
  input  logic [pafk_pkg::APB_DW-1:0]         pwdata,
  output logic [pafk_pkg::APB_DW-1:0]         prdata,
  output logic                                pready
);

  localparam int W = pafk_pkg::WRAP_STEPS;
  localparam int N = CORDIC_STEPS;

  // configuration
  logic [pafk_pkg::LEN_W-1:0] first_link_length;
  logic [pafk_pkg::LEN_W-1:0] second_link_length;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_link_length  <= pafk_pkg::LINK_RESET;
      second_link_length <= pafk_pkg::LINK_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2])
        pafk_pkg::REG_FIRST_LINK:  first_link_length  <= pwdata[pafk_pkg::LEN_W-1:0];
        pafk_pkg::REG_SECOND_LINK: second_link_length <= pwdata[pafk_pkg::LEN_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      pafk_pkg::REG_FIRST_LINK:  prdata = pafk_pkg::APB_DW'(first_link_length);
      pafk_pkg::REG_SECOND_LINK: prdata = pafk_pkg::APB_DW'(second_link_length);
    endcase
  end

  // pipeline advance
  logic skid_valid;
  logic advance;

  assign advance  = ~skid_valid;
  assign s_tready = advance;

  // input sums
  logic signed [pafk_pkg::ANG_W-1:0]    t1;
  logic signed [pafk_pkg::ANG_W-1:0]    t2;
  logic signed [pafk_pkg::ANG_W-1:0]    t3;
  logic signed [pafk_pkg::SUM_A_W-1:0]  a_sum;
  logic signed [pafk_pkg::SUM_B_W-1:0]  b_sum;
  logic signed [pafk_pkg::WRAP_W-1:0]   za_in;
  logic signed [pafk_pkg::WRAP_W-1:0]   zb_in;

  assign t1    = s_tdata[15:0];
  assign t2    = s_tdata[31:16];
  assign t3    = s_tdata[47:32];
  assign a_sum = pafk_pkg::SUM_A_W'(t1) + pafk_pkg::SUM_A_W'(t2);
  assign b_sum = pafk_pkg::SUM_B_W'(a_sum) + pafk_pkg::SUM_B_W'(t3);
  assign za_in = pafk_pkg::WRAP_W'(a_sum) <<< pafk_pkg::ANG_SHIFT;
  assign zb_in = pafk_pkg::WRAP_W'(b_sum) <<< pafk_pkg::ANG_SHIFT;

  // wrap stages, index 0 is the input register
  logic                               wv   [0:W];
  logic signed [pafk_pkg::WRAP_W-1:0] wza  [0:W];
  logic signed [pafk_pkg::WRAP_W-1:0] wzb  [0:W];
  pafk_pkg::meta_t                    wm   [0:W];

  always_ff @(posedge clk) begin
    if (rst) begin
      wv[0] <= 1'b0;
    end else if (advance) begin
      wv[0] <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      wza[0]       <= za_in;
      wzb[0]       <= zb_in;
      wm[0].stroke <= s_tdata[65:48];
      wm[0].tool   <= b_sum;
    end
  end

  for (genvar k = 0; k < W; k++) begin : g_wrap
    always_ff @(posedge clk) begin
      if (rst) begin
        wv[k+1] <= 1'b0;
      end else if (advance) begin
        wv[k+1] <= wv[k];
      end
    end

    always_ff @(posedge clk) begin
      if (advance) begin
        wza[k+1] <= pafk_pkg::wrap_step(wza[k]);
        wzb[k+1] <= pafk_pkg::wrap_step(wzb[k]);
        wm[k+1]  <= wm[k];
      end
    end
  end

  // fold and CORDIC stages, index 0 is the fold register
  pafk_pkg::fold_t   fold_a;
  pafk_pkg::fold_t   fold_b;
  logic              cv     [0:N];
  pafk_pkg::cordic_t ca     [0:N];
  pafk_pkg::cordic_t cb     [0:N];
  logic              flip_a [0:N];
  logic              flip_b [0:N];
  pafk_pkg::meta_t   cm     [0:N];

  assign fold_a = pafk_pkg::fold_half(wza[W]);
  assign fold_b = pafk_pkg::fold_half(wzb[W]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cv[0] <= 1'b0;
    end else if (advance) begin
      cv[0] <= wv[W];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      ca[0].x   <= pafk_pkg::GAIN_Q30;
      ca[0].y   <= '0;
      ca[0].z   <= fold_a.z;
      cb[0].x   <= pafk_pkg::GAIN_Q30;
      cb[0].y   <= '0;
      cb[0].z   <= fold_b.z;
      flip_a[0] <= fold_a.flip;
      flip_b[0] <= fold_b.flip;
      cm[0]     <= wm[W];
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_cordic
    always_ff @(posedge clk) begin
      if (rst) begin
        cv[i+1] <= 1'b0;
      end else if (advance) begin
        cv[i+1] <= cv[i];
      end
    end

    always_ff @(posedge clk) begin
      if (advance) begin
        ca[i+1]     <= pafk_pkg::cordic_step(ca[i], i);
        cb[i+1]     <= pafk_pkg::cordic_step(cb[i], i);
        flip_a[i+1] <= flip_a[i];
        flip_b[i+1] <= flip_b[i];
        cm[i+1]     <= cm[i];
      end
    end
  end

  // sign restore
  logic                              gv;
  logic signed [pafk_pkg::XY_W-1:0]  cos_a;
  logic signed [pafk_pkg::XY_W-1:0]  sin_a;
  logic signed [pafk_pkg::XY_W-1:0]  cos_b;
  logic signed [pafk_pkg::XY_W-1:0]  sin_b;
  pafk_pkg::meta_t                   gm;

  always_ff @(posedge clk) begin
    if (rst) begin
      gv <= 1'b0;
    end else if (advance) begin
      gv <= cv[N];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      cos_a <= flip_a[N] ? -ca[N].x : ca[N].x;
      sin_a <= flip_a[N] ? -ca[N].y : ca[N].y;
      cos_b <= flip_b[N] ? -cb[N].x : cb[N].x;
      sin_b <= flip_b[N] ? -cb[N].y : cb[N].y;
      gm    <= cm[N];
    end
  end

  // link products, Q45
  logic                               pv;
  logic signed [pafk_pkg::PROD_W-1:0] prod_xa;
  logic signed [pafk_pkg::PROD_W-1:0] prod_xb;
  logic signed [pafk_pkg::PROD_W-1:0] prod_ya;
  logic signed [pafk_pkg::PROD_W-1:0] prod_yb;
  pafk_pkg::meta_t                    pm;

  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= 1'b0;
    end else if (advance) begin
      pv <= gv;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      prod_xa <= pafk_pkg::PROD_W'($signed({1'b0, first_link_length})) *
                 pafk_pkg::PROD_W'(cos_a);
      prod_xb <= pafk_pkg::PROD_W'($signed({1'b0, second_link_length})) *
                 pafk_pkg::PROD_W'(cos_b);
      prod_ya <= pafk_pkg::PROD_W'($signed({1'b0, first_link_length})) *
                 pafk_pkg::PROD_W'(sin_a);
      prod_yb <= pafk_pkg::PROD_W'($signed({1'b0, second_link_length})) *
                 pafk_pkg::PROD_W'(sin_b);
      pm      <= gm;
    end
  end

  // sum, round, saturate
  logic                               rv;
  logic [pafk_pkg::OUT_W-1:0]         pos_x;
  logic [pafk_pkg::OUT_W-1:0]         pos_y;
  pafk_pkg::meta_t                    rm;
  logic signed [pafk_pkg::SUM_W-1:0]  sum_x;
  logic signed [pafk_pkg::SUM_W-1:0]  sum_y;

  assign sum_x = pafk_pkg::SUM_W'(prod_xa) + pafk_pkg::SUM_W'(prod_xb);
  assign sum_y = pafk_pkg::SUM_W'(prod_ya) + pafk_pkg::SUM_W'(prod_yb);

  always_ff @(posedge clk) begin
    if (rst) begin
      rv <= 1'b0;
    end else if (advance) begin
      rv <= pv;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      pos_x <= pafk_pkg::sat_q14(sum_x);
      pos_y <= pafk_pkg::sat_q14(sum_y);
      rm    <= pm;
    end
  end

  // output register and skid
  logic                                push;
  logic                                out_free;
  logic [pafk_pkg::OUT_TDATA_W-1:0]    push_word;
  logic [pafk_pkg::OUT_TDATA_W-1:0]    skid_word;

  assign push      = advance & rv;
  assign out_free  = ~m_tvalid | m_tready;
  assign push_word = {rm.tool, rm.stroke, pos_y, pos_x};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      m_tvalid   <= skid_valid | push;
      skid_valid <= 1'b0;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      m_tdata <= skid_valid ? skid_word : push_word;
    end else if (push) begin
      skid_word <= push_word;
    end
  end

  // checks
  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> m_tvalid)
    else $error("skid word held with empty output register");

  a_skid_holds: assert property (@(posedge clk) disable iff (rst)
    skid_valid && !m_tready |=> skid_valid && m_tvalid)
    else $error("skid word dropped while output stalled");

  a_wrap_range: assert property (@(posedge clk) disable iff (rst)
    wv[W] |-> (wza[W] >= -pafk_pkg::PI_Q30) && (wza[W] < pafk_pkg::PI_Q30) &&
              (wzb[W] >= -pafk_pkg::PI_Q30) && (wzb[W] < pafk_pkg::PI_Q30))
    else $error("angle left wrap range");

  a_fold_range: assert property (@(posedge clk) disable iff (rst)
    cv[0] |-> (pafk_pkg::WRAP_W'(ca[0].z) <= pafk_pkg::HALF_PI_Q30) &&
              (pafk_pkg::WRAP_W'(ca[0].z) >= -pafk_pkg::HALF_PI_Q30) &&
              (pafk_pkg::WRAP_W'(cb[0].z) <= pafk_pkg::HALF_PI_Q30) &&
              (pafk_pkg::WRAP_W'(cb[0].z) >= -pafk_pkg::HALF_PI_Q30))
    else $error("folded angle outside half plane");

  a_stall_holds_pipe: assert property (@(posedge clk) disable iff (rst)
    !advance && rv |=> rv)
    else $error("pipeline word lost during stall");

endmodule
